// ===== rtl/bmf_pkg.sv =====
package bmf_pkg;

    // Register and position widths
    localparam int W_W   = 12;
    localparam int H_W   = 13;
    localparam int CFG_W = 13;
    localparam int IDX_W = 1;
    localparam int POS_W = W_W + H_W;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // Input item kinds
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Result queue sizing
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int PEND_W     = 4;

    typedef struct packed {
        logic       cmd;
        logic [7:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] value;
        logic       last_of_frame;
    } t_out_beat;

    // Per-item control handed from the sequencer to the sum pipeline
    typedef struct packed {
        logic pix;
        logic emit;
        logic interior;
        logic last;
        logic first_row;
        logic full_rows;
        logic first_col;
        logic col_ge_win;
    } t_item_ctl;

    // Result control travelling with a window sum
    typedef struct packed {
        logic valid;
        logic interior;
        logic last;
    } t_res_ctl;

endpackage

// ===== rtl/bmf_sum_core.sv =====
module bmf_sum_core #(
    parameter int WINDOW    = 35,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bmf_pkg::t_item_ctl              i_ctl,
    input  logic [7:0]                      i_sample,
    input  logic [$clog2(WINDOW)-1:0]       i_wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]    i_wr_col,
    input  logic [$clog2(WINDOW)-1:0]       i_rd_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]    i_rd_col,
    output bmf_pkg::t_res_ctl               o_res,
    output logic [7:0]                      o_border,
    output logic [$clog2(WINDOW*WINDOW*255+1)-1:0] o_sum
);

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CS_W     = $clog2(WINDOW * 255 + 1);
    localparam int SUM_W    = $clog2(WINDOW * WINDOW * 255 + 1);
    localparam int LS_DEPTH = WINDOW * MAX_WIDTH;
    localparam int LS_AW    = $clog2(LS_DEPTH);

    // Line store and column sums
    logic [7:0]      r_ls [LS_DEPTH];
    logic [CS_W-1:0] r_cs_mem [MAX_WIDTH];

    logic [LS_AW-1:0] wr_addr;
    logic [LS_AW-1:0] rd_addr;

    // Read stage outputs
    logic [7:0]      r_ls_old;
    logic [7:0]      r_ls_border;
    logic [CS_W-1:0] r_cs_rd;

    // Update stage
    bmf_pkg::t_item_ctl r_b_ctl;
    logic [COL_W-1:0]   r_b_col;
    logic [7:0]         r_b_sample;
    logic               r_fwd_hit;
    logic [CS_W-1:0]    r_fwd_cs;
    logic [CS_W-1:0]    r_dl [WINDOW];
    logic [SUM_W-1:0]   r_ws;

    // Result stage
    bmf_pkg::t_res_ctl r_c_res;
    logic [7:0]        r_c_border;

    logic [CS_W-1:0]  cs_base;
    logic [CS_W-1:0]  cs_keep;
    logic [CS_W-1:0]  cs_drop;
    logic [CS_W-1:0]  cs_new;
    logic [SUM_W-1:0] ws_keep;
    logic [SUM_W-1:0] ws_drop;
    logic [SUM_W-1:0] ws_new;

    // Map ring row and column to a flat line-store address
    assign wr_addr = LS_AW'(i_wr_slot) * LS_AW'(MAX_WIDTH) + LS_AW'(i_wr_col);
    assign rd_addr = LS_AW'(i_rd_slot) * LS_AW'(MAX_WIDTH) + LS_AW'(i_rd_col);

    // Write the new sample, read the sample it replaces and the border sample
    always_ff @(posedge i_clk) begin
        if (i_ctl.pix) begin
            r_ls[wr_addr] <= i_sample;
        end
        r_ls_old    <= r_ls[wr_addr];
        r_ls_border <= r_ls[rd_addr];
    end

    // Column sum read now, written back when the update stage retires
    always_ff @(posedge i_clk) begin
        if (r_b_ctl.pix) begin
            r_cs_mem[r_b_col] <= cs_new;
        end
        r_cs_rd <= r_cs_mem[i_wr_col];
    end

    // Forward a column sum written at the same edge it was read (one-pixel rows)
    assign cs_base = r_fwd_hit ? r_fwd_cs : r_cs_rd;
    assign cs_keep = r_b_ctl.first_row ? '0 : cs_base;
    assign cs_drop = r_b_ctl.full_rows ? CS_W'(r_ls_old) : '0;
    assign cs_new  = cs_keep + CS_W'(r_b_sample) - cs_drop;

    // Slide the window sum along the row
    assign ws_keep = r_b_ctl.first_col ? '0 : r_ws;
    assign ws_drop = r_b_ctl.col_ge_win ? SUM_W'(r_dl[WINDOW-1]) : '0;
    assign ws_new  = ws_keep + SUM_W'(cs_new) - ws_drop;

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl   <= '0;
            r_fwd_hit <= 1'b0;
            r_c_res   <= '0;
        end else begin
            r_b_ctl   <= i_ctl;
            r_fwd_hit <= i_ctl.pix && r_b_ctl.pix && (i_wr_col == r_b_col);
            r_c_res.valid    <= r_b_ctl.emit;
            r_c_res.interior <= r_b_ctl.interior;
            r_c_res.last     <= r_b_ctl.last;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        r_b_col    <= i_wr_col;
        r_b_sample <= i_sample;
        r_fwd_cs   <= cs_new;
        r_c_border <= r_ls_border;
        if (r_b_ctl.pix) begin
            r_ws    <= ws_new;
            r_dl[0] <= cs_new;
            for (int i = 1; i < WINDOW; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    assign o_res    = r_c_res;
    assign o_border = r_c_border;
    assign o_sum    = r_ws;

endmodule

// ===== rtl/bmf_div.sv =====
module bmf_div #(
    parameter int WINDOW = 35
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bmf_pkg::t_res_ctl                      i_res,
    input  logic [7:0]                             i_border,
    input  logic [$clog2(WINDOW*WINDOW*255+1)-1:0] i_sum,
    output logic                                   o_push,
    output bmf_pkg::t_out_beat                     o_beat
);

    localparam int SUM_W   = $clog2(WINDOW * WINDOW * 255 + 1);
    localparam int AREA    = WINDOW * WINDOW;
    localparam int SHIFT   = SUM_W + $clog2(AREA);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // Rounded-up reciprocal: exact floor division for every sum below 2^SUM_W
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(AREA) - 64'd1) / 64'(AREA);

    bmf_pkg::t_res_ctl  r_d_res;
    logic [PROD_W-1:0]  r_d_prod;
    logic [7:0]         r_d_border;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_res <= '0;
        end else begin
            r_d_res <= i_res;
        end
    end

    // Multiply by the reciprocal
    always_ff @(posedge i_clk) begin
        r_d_prod   <= PROD_W'(i_sum) * PROD_W'(RECIP_W'(RECIP));
        r_d_border <= i_border;
    end

    // Pick the mean or the pass-through sample
    assign o_push               = r_d_res.valid;
    assign o_beat.value         = r_d_res.interior ? r_d_prod[SHIFT +: 8] : r_d_border;
    assign o_beat.last_of_frame = r_d_res.last;

endmodule

// ===== rtl/bmf_out_fifo.sv =====
module bmf_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bmf_pkg::t_out_beat i_beat,
    output logic               o_valid,
    input  logic               i_stall,
    output bmf_pkg::t_out_beat o_beat
);

    bmf_pkg::t_out_beat                r_mem [bmf_pkg::FIFO_DEPTH];
    logic [bmf_pkg::FIFO_AW-1:0]       r_wr_ptr;
    logic [bmf_pkg::FIFO_AW-1:0]       r_rd_ptr;
    logic [bmf_pkg::PEND_W-1:0]        r_count;
    logic                              pop;

    assign o_valid = r_count != '0;
    assign o_beat  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    // Store result beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + bmf_pkg::PEND_W'(i_push) - bmf_pkg::PEND_W'(pop);
        end
    end

endmodule

// ===== rtl/box_mean_filter_2d.sv =====
// Streaming WINDOW x WINDOW box-mean filter over 8-bit samples in raster order. One item is
// taken every clock while the input is not stalled: each pixel writes the line store (a ring
// of WINDOW rows, MAX_WIDTH wide) while the sample it replaces and the pass-through sample are
// read on two read ports, the column-sum memory is read, updated and written back (with
// forwarding for one-pixel rows), and the window sum slides by one column. A pixel's result
// leaves HALF*width+HALF items after its own sample (HALF = WINDOW/2); interior pixels give
// sum/(WINDOW*WINDOW) via a reciprocal multiply, border pixels their own sample, and drain
// items push out the tail of the frame. A result is registered in the update, result and
// multiply stages and then waits in an eight-beat queue; input stalls once eight results are
// outstanding. After reset and after each register write the input stalls while frame length
// and lag settle. Frames smaller than WINDOW*WINDOW pixels produce nothing. No clearing pass
// is needed: the first row of each frame rebuilds the column sums.
module box_mean_filter_2d #(
    parameter int WINDOW    = 35,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bmf_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bmf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bmf_pkg::t_in_beat           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bmf_pkg::t_out_beat          o_out_data
);

    localparam int POS_W    = bmf_pkg::POS_W;
    localparam int W_W      = bmf_pkg::W_W;
    localparam int H_W      = bmf_pkg::H_W;
    localparam int PEND_W   = bmf_pkg::PEND_W;
    localparam int HALF     = WINDOW / 2;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int RC_W     = $clog2(WINDOW + 1);
    localparam int SUM_W    = $clog2(WINDOW * WINDOW * 255 + 1);
    localparam int WIN_AREA = WINDOW * WINDOW;
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // Configuration and derived frame geometry
    logic [W_W-1:0]    r_width;
    logic [H_W-1:0]    r_height;
    logic [1:0]        r_settle;
    logic [W_W-1:0]    r_eff_w;
    logic [POS_W-1:0]  r_frame_n;
    logic [POS_W-1:0]  r_lag;
    logic              r_small;

    // Input and output positions
    logic [POS_W-1:0]  r_in_pos;
    logic [POS_W-1:0]  r_out_pos;
    logic [COL_W-1:0]  r_in_col;
    logic [SLOT_W-1:0] r_in_slot;
    logic [RC_W-1:0]   r_in_rows;
    logic [COL_W-1:0]  r_out_col;
    logic [H_W-1:0]    r_out_row;
    logic [SLOT_W-1:0] r_out_slot;
    logic [PEND_W-1:0] r_pending;

    logic               acc;
    logic               pop;
    logic               is_pix;
    logic               in_room;
    logic               take_pix;
    logic               emit;
    logic               last;
    logic               interior;
    logic               clear_pos;
    logic               in_col_end;
    logic               out_col_end;
    logic [PEND_W-1:0]  n_pending;
    bmf_pkg::t_item_ctl ctl;

    bmf_pkg::t_res_ctl  core_res;
    logic [7:0]         core_border;
    logic [SUM_W-1:0]   core_sum;
    logic               div_push;
    bmf_pkg::t_out_beat div_beat;

    // Hold off input while geometry settles or the result queue could overflow
    assign o_in_stall = (r_settle != 2'd0) || (r_pending >= PEND_W'(bmf_pkg::FIFO_DEPTH));
    assign acc        = i_in_valid && !o_in_stall;
    assign pop        = o_out_valid && !i_out_stall;

    // Decide what the beat does
    assign is_pix   = i_in_data.cmd == bmf_pkg::CMD_PIXEL;
    assign in_room  = r_in_pos < r_frame_n;
    assign take_pix = acc && is_pix && !r_small && in_room;
    assign emit     = acc && !r_small &&
                      (is_pix ? (in_room && r_in_pos >= r_lag)
                              : (r_in_pos == r_frame_n && r_out_pos < r_frame_n));
    assign last     = (r_out_pos + POS_W'(1)) == r_frame_n;
    assign interior = (POS_W'(r_out_row) >= POS_W'(HALF)) &&
                      (POS_W'(r_out_row) + POS_W'(HALF) < POS_W'(r_height)) &&
                      (POS_W'(r_out_col) > POS_W'(HALF)) &&
                      (POS_W'(r_out_col) + POS_W'(HALF) < POS_W'(r_eff_w));
    assign clear_pos   = i_cfg_we || (emit && last);
    assign in_col_end  = POS_W'(r_in_col) + POS_W'(1) == POS_W'(r_eff_w);
    assign out_col_end = POS_W'(r_out_col) + POS_W'(1) == POS_W'(r_eff_w);
    assign n_pending   = r_pending + PEND_W'(emit) - PEND_W'(pop);

    always_comb begin
        ctl.pix        = take_pix;
        ctl.emit       = emit;
        ctl.interior   = interior;
        ctl.last       = last;
        ctl.first_row  = r_in_rows == '0;
        ctl.full_rows  = r_in_rows == RC_W'(WINDOW);
        ctl.first_col  = r_in_col == '0;
        ctl.col_ge_win = POS_W'(r_in_col) >= POS_W'(WINDOW);
    end

    // Derive frame geometry from the registers
    always_ff @(posedge i_clk) begin
        r_eff_w   <= (POS_W'(r_width) > POS_W'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : r_width;
        r_frame_n <= POS_W'(r_eff_w) * POS_W'(r_height);
        r_lag     <= POS_W'(HALF) * POS_W'(r_eff_w) + POS_W'(HALF);
        r_small   <= (r_eff_w == '0) || (r_frame_n < POS_W'(WIN_AREA));
    end

    // Registers, positions and the outstanding-result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= W_W'(64);
            r_height   <= H_W'(64);
            r_settle   <= SETTLE_CYCLES;
            r_in_pos   <= '0;
            r_out_pos  <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_in_rows  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_pending  <= '0;
        end else begin
            r_pending <= n_pending;
            if (i_cfg_we) begin
                r_settle <= SETTLE_CYCLES;
                case (i_cfg_idx)
                    bmf_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[W_W-1:0];
                    bmf_pkg::CFG_HEIGHT: r_height <= i_cfg_data[H_W-1:0];
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end

            if (clear_pos) begin
                r_in_pos   <= '0;
                r_out_pos  <= '0;
                r_in_col   <= '0;
                r_in_slot  <= '0;
                r_in_rows  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
            end else begin
                // Advance the write position
                if (take_pix) begin
                    r_in_pos <= r_in_pos + POS_W'(1);
                    if (in_col_end) begin
                        r_in_col  <= '0;
                        r_in_slot <= (r_in_slot == SLOT_W'(WINDOW - 1)) ? '0
                                                                         : r_in_slot + 1'b1;
                        if (r_in_rows != RC_W'(WINDOW)) begin
                            r_in_rows <= r_in_rows + 1'b1;
                        end
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                end
                // Advance the result position
                if (emit) begin
                    r_out_pos <= r_out_pos + POS_W'(1);
                    if (out_col_end) begin
                        r_out_col  <= '0;
                        r_out_row  <= r_out_row + 1'b1;
                        r_out_slot <= (r_out_slot == SLOT_W'(WINDOW - 1)) ? '0
                                                                           : r_out_slot + 1'b1;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
            end
        end
    end

    bmf_sum_core #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_sample  (i_in_data.sample),
        .i_wr_slot (r_in_slot),
        .i_wr_col  (r_in_col),
        .i_rd_slot (r_out_slot),
        .i_rd_col  (r_out_col),
        .o_res     (core_res),
        .o_border  (core_border),
        .o_sum     (core_sum)
    );

    bmf_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (core_res),
        .i_border (core_border),
        .i_sum    (core_sum),
        .o_push   (div_push),
        .o_beat   (div_beat)
    );

    bmf_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (div_push),
        .i_beat  (div_beat),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (o_out_data)
    );

    // Outstanding results never exceed the queue
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(bmf_pkg::FIFO_DEPTH))
        else $error("outstanding result count above queue depth");

    // A queued beat is always counted as outstanding
    a_queue_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != '0)
        else $error("result queued without outstanding count");

    // Results never run ahead of samples, and samples stay within the frame
    a_pos_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settle == 2'd0) |-> (r_out_pos <= r_in_pos && r_in_pos <= r_frame_n))
        else $error("position out of order");

    // The final result of a frame restarts both positions
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> (r_in_pos == '0 && r_out_pos == '0))
        else $error("frame did not restart after its last result");

endmodule

// ===== verif/box_mean_check.sv =====
module box_mean_check #(
    parameter int WINDOW    = 35,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bmf_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bmf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  bmf_pkg::t_in_beat           i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  bmf_pkg::t_out_beat          i_out_data,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_checked
);

    localparam int HALF = WINDOW / 2;
    localparam int AREA = WINDOW * WINDOW;

    // Own copy of the row ring; two-state so an untouched slot reads zero
    bit   [7:0]              row_ring [WINDOW*MAX_WIDTH];
    logic [bmf_pkg::W_W-1:0] width_reg;
    logic [bmf_pkg::H_W-1:0] height_reg;
    int unsigned             pixels_taken;
    int unsigned             results_given;
    bmf_pkg::t_out_beat      filtered_q[$];

    function automatic int unsigned clipped_width();
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function automatic int unsigned ring_slot(int unsigned row, int unsigned col);
        return (row % WINDOW) * MAX_WIDTH + (col % MAX_WIDTH);
    endfunction

    // Truncated mean of the full neighborhood centered on (r, c)
    function automatic logic [7:0] window_mean(int unsigned r, int unsigned c);
        int unsigned acc;
        acc = 0;
        for (int j = 0; j < WINDOW; j++)
            for (int k = 0; k < WINDOW; k++)
                acc += row_ring[ring_slot(r - HALF + j, c - HALF + k)];
        return 8'(acc / AREA);
    endfunction

    // Queue the next delayed pixel result and advance the output position
    task automatic emit_filtered(int unsigned n);
        int unsigned        w, r, c;
        bmf_pkg::t_out_beat res;
        w = clipped_width();
        r = results_given / w;
        c = results_given % w;
        if (r >= HALF && r + HALF < height_reg && c > HALF && c + HALF < w) begin
            res.value = window_mean(r, c);
        end else begin
            res.value = row_ring[ring_slot(r, c)];
        end
        res.last_of_frame = (results_given == n - 1);
        filtered_q.push_back(res);
        results_given++;
        if (results_given >= n) begin
            results_given = 0;
            pixels_taken  = 0;
        end
    endtask

    // Predict what one accepted input beat causes
    task automatic take_beat(bmf_pkg::t_in_beat beat);
        int unsigned w, n, lag;
        w = clipped_width();
        n = w * height_reg;
        if (w == 0 || n < AREA) return;
        lag = HALF * w + HALF;
        if (beat.cmd == bmf_pkg::CMD_PIXEL) begin
            // drop pixels once the frame is full and still draining
            if (pixels_taken < n) begin
                row_ring[ring_slot(pixels_taken / w, pixels_taken % w)] = beat.sample;
                pixels_taken++;
                if (pixels_taken > lag + results_given) emit_filtered(n);
            end
        end else if (pixels_taken == n && results_given < n) begin
            emit_filtered(n);
        end
    endtask

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg     = 12'd64;
            height_reg    = 13'd64;
            pixels_taken  = 0;
            results_given = 0;
            filtered_q.delete();
            o_errors      = 0;
            o_checked     = 0;
        end else begin
            // Compare the result beat with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    report($sformatf("result beat with nothing expected: value %0d last %0b",
                                     i_out_data.value, i_out_data.last_of_frame));
                end else begin
                    bmf_pkg::t_out_beat want;
                    want = filtered_q.pop_front();
                    o_checked++;
                    if (i_out_data.value !== want.value)
                        report($sformatf("result %0d: value %0d, expected %0d", o_checked,
                                         i_out_data.value, want.value));
                    if (i_out_data.last_of_frame !== want.last_of_frame)
                        report($sformatf("result %0d: last_of_frame %0b, expected %0b",
                                         o_checked, i_out_data.last_of_frame,
                                         want.last_of_frame));
                end
            end
            // Register writes restart the frame
            if (i_cfg_we) begin
                if (i_cfg_idx == bmf_pkg::CFG_WIDTH) width_reg = i_cfg_data[bmf_pkg::W_W-1:0];
                else height_reg = i_cfg_data[bmf_pkg::H_W-1:0];
                pixels_taken  = 0;
                results_given = 0;
            end
            if (i_in_valid && !i_in_stall) take_beat(i_in_data);
        end
        o_pending = filtered_q.size();
    end

endmodule

// ===== verif/box_mean_filter_2d_test.sv =====
module box_mean_filter_2d_test;

    localparam int WINDOW    = 35;
    localparam int MAX_WIDTH = 2048;

    typedef enum int {FILL_RANDOM, FILL_HIGH, FILL_LOW, FILL_MIXED} t_fill;
    typedef enum int {
        PACE_STEADY, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH, PACE_SQUEEZE
    } t_pace;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [bmf_pkg::IDX_W-1:0] cfg_idx;
    logic [bmf_pkg::CFG_W-1:0] cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    bmf_pkg::t_in_beat         in_data;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    bmf_pkg::t_out_beat        out_data;

    int                        errors;
    int                        pending;
    int                        checked;

    int                        idle_pct;
    int                        stall_pct;
    bit                        hold_req;
    bit                        hold_done;
    int                        hold_left;
    logic [bmf_pkg::W_W-1:0]   cur_w;
    logic [bmf_pkg::H_W-1:0]   cur_h;
    int                        frames;
    int                        beats_sent;

    box_mean_filter_2d #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    box_mean_check #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver stalls at random; one long hold-off on request
    always @(negedge clk) begin
        if (hold_req && !hold_done) begin
            hold_left = 300;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [7:0] pick_sample(t_fill fill);
        case (fill)
            FILL_HIGH: return 8'hFF;
            FILL_LOW:  return 8'h00;
            FILL_MIXED: begin
                if ($urandom_range(1)) return $urandom_range(1) ? 8'hFF : 8'h00;
                return 8'($urandom);
            end
            default:   return 8'($urandom);
        endcase
    endfunction

    // Offer one input beat after a random gap and hold it until taken
    task automatic send_beat(input logic cmd, input logic [7:0] smp);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        in_data.cmd    <= cmd;
        in_data.sample <= smp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    // Go quiet and wait for every expected result plus the pipeline tail
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bmf_pkg::IDX_W-1:0] idx,
                             input logic [bmf_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (idx == bmf_pkg::CFG_WIDTH) cur_w = data[bmf_pkg::W_W-1:0];
        else                           cur_h = data[bmf_pkg::H_W-1:0];
    endtask

    task automatic set_size(input logic [bmf_pkg::CFG_W-1:0] w_data,
                            input logic [bmf_pkg::CFG_W-1:0] h_data);
        write_reg(bmf_pkg::CFG_WIDTH, w_data);
        write_reg(bmf_pkg::CFG_HEIGHT, h_data);
    endtask

    // Stream one frame: pixels, then drains; cut > 0 stops after that many pixels.
    // Noise adds early drains, pixels during draining and drains after the end.
    task automatic run_frame(input t_fill fill, input t_pace pace, input bit noisy,
                             input int cut);
        int w, n, lag, drains, npix;
        case (pace)
            PACE_SENDER_IDLE:    begin idle_pct = 60; stall_pct = 0;  end
            PACE_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 60; end
            PACE_BOTH:           begin idle_pct = 16; stall_pct = 16; end
            default:             begin idle_pct = 0;  stall_pct = 0;  end
        endcase
        frames++;
        w = (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
        n = w * cur_h;
        if (w == 0 || n < WINDOW * WINDOW) begin
            // frame too small: everything here is ignored
            repeat (10) send_beat(1'($urandom_range(1)), 8'($urandom));
        end else begin
            lag    = (WINDOW / 2) * w + WINDOW / 2;
            drains = (n < lag) ? n : lag;
            npix   = (cut > 0) ? cut : n;
            for (int i = 0; i < npix; i++) begin
                if (noisy && $urandom_range(99) < 3)
                    send_beat(bmf_pkg::CMD_DRAIN, 8'($urandom));
                if (pace == PACE_SQUEEZE && i == lag + 50) hold_req = 1'b1;
                send_beat(bmf_pkg::CMD_PIXEL, pick_sample(fill));
            end
            if (cut == 0) begin
                for (int i = 0; i < drains; i++) begin
                    if (noisy && $urandom_range(99) < 3)
                        send_beat(bmf_pkg::CMD_PIXEL, 8'($urandom));
                    send_beat(bmf_pkg::CMD_DRAIN, 8'($urandom));
                end
                if (noisy) repeat (2) send_beat(bmf_pkg::CMD_DRAIN, 8'($urandom));
            end
        end
        settle();
    endtask

    initial begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = bmf_pkg::CFG_WIDTH;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        hold_left  = 0;
        cur_w      = 12'd64;
        cur_h      = 13'd64;
        frames     = 0;
        beats_sent = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Size left at reset, cut short just after the first results
        run_frame(FILL_MIXED, PACE_STEADY, 1'b1, 1120);
        // Degenerate sizes: zero width, zero height, one pixel short of a window
        set_size(13'd0, 13'd64);
        run_frame(FILL_RANDOM, PACE_BOTH, 1'b0, 0);
        set_size(13'd36, 13'd0);
        run_frame(FILL_RANDOM, PACE_STEADY, 1'b0, 0);
        set_size(13'd36, 13'd34);
        run_frame(FILL_RANDOM, PACE_SENDER_IDLE, 1'b0, 0);
        // One-pixel rows: all border, column sums forwarded between beats
        set_size(13'd1, 13'd1225);
        run_frame(FILL_RANDOM, PACE_SENDER_IDLE, 1'b1, 0);
        // Smallest frame with an interior pixel, saturated sum
        set_size(13'd36, 13'd35);
        run_frame(FILL_HIGH, PACE_RECEIVER_STALL, 1'b1, 0);
        // Upper data bit on the width write is dropped; long receiver hold
        set_size(13'h1000 | 13'd37, 13'd36);
        run_frame(FILL_MIXED, PACE_SQUEEZE, 1'b1, 0);
        // Next frame follows with no register write
        run_frame(FILL_RANDOM, PACE_BOTH, 1'b0, 0);

        $display("covered %0d frames: degenerate sizes, one-pixel rows, small interiors",
                 frames);
        $display("sent %0d input beats, checked %0d filtered results", beats_sent, checked);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(12 * 200000);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bmf_pkg.sv
rtl/bmf_sum_core.sv
rtl/bmf_div.sv
rtl/bmf_out_fifo.sv
rtl/box_mean_filter_2d.sv
verif/box_mean_check.sv
verif/box_mean_filter_2d_test.sv
